### hw/rtl/bcsf_pkg.sv
package bcsf_pkg;

    // Beat payloads
    typedef struct packed {
        logic kind;
        logic wall_in;
    } in_beat_t;

    typedef struct packed {
        logic wall_out;
        logic frame_last;
    } out_beat_t;

    // Input beat kinds
    localparam logic KIND_CELL = 1'b0;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam int GW_BITS    = 11;   // grid_width register
    localparam int GH_BITS    = 13;   // grid_height register, also row counter
    localparam int MIN_SIZE   = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int RESET_SIZE = 64;

    // 3x3 window: bit row*3+col, row 0 on top, col 0 oldest
    localparam int WIN_CENTRE    = 4;
    localparam int WIN_MID_RIGHT = 5;
    localparam logic [8:0] MASK_TOP   = 9'b000_000_111;
    localparam logic [8:0] MASK_BOT   = 9'b111_000_000;
    localparam logic [8:0] MASK_LEFT  = 9'b001_001_001;
    localparam logic [8:0] MASK_RIGHT = 9'b100_100_100;
    localparam int KEEP_COUNT = 4;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // 4-5 rule on the shifted window; forced marks neighbours on the outer ring
    function automatic logic smooth_rule(logic [8:0] win, logic [8:0] forced);
        logic [8:0] nb;
        logic [3:0] count;
        logic       res;
        nb = win | forced;
        count = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != WIN_CENTRE)
            begin
                count = count + 4'(nb[i]);
            end
        end
        if (count > 4'(KEEP_COUNT))
        begin
            res = 1'b1;
        end
        else if (count < 4'(KEEP_COUNT))
        begin
            res = 1'b0;
        end
        else
        begin
            res = win[WIN_CENTRE];
        end
        return res;
    endfunction

endpackage

### hw/rtl/bcsf_out_queue.sv
module bcsf_out_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  bcsf_pkg::out_beat_t             push_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output bcsf_pkg::out_beat_t             out_data,
    output logic [bcsf_pkg::OQ_CW-1:0]      fill
);

    bcsf_pkg::out_beat_t             q_mem [bcsf_pkg::OQ_DEPTH];
    logic [bcsf_pkg::OQ_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [bcsf_pkg::OQ_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [bcsf_pkg::OQ_CW-1:0]      fill_reg, fill_next;
    logic                            pop;

    assign out_valid = (fill_reg != '0);
    assign out_data  = q_mem[rd_ptr_reg];
    assign fill      = fill_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + bcsf_pkg::OQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + bcsf_pkg::OQ_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + bcsf_pkg::OQ_CW'(push) - bcsf_pkg::OQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/binary_cave_smoothing_filter.sv
// Channel   Direction  Handshake              Beat
// in        sink       in_valid / in_ready    in_data   {kind, wall_in}
// out       source     out_valid / out_ready  out_data  {wall_out, frame_last}
// cfg       sink       cfg_we                 cfg_index, cfg_data (no wait, no read-back)
//
// One beat per cycle sustained while in_ready is high. A cell is pushed into the
// four-entry output queue by the window stage of the beat that completes its
// 3x3 window. The line store is a single 2-bit-wide synchronous RAM (upper,
// middle), read and written once per beat; its registered read is covered by
// forwarding when a frame restart reuses column 0 back to back.
// Reset clears counters, window and queue; the line store is not cleared.
// in_ready drops only when the queue plus the beat in flight could overfill it.
module binary_cave_smoothing_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bcsf_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bcsf_pkg::out_beat_t                 out_data,
    input  logic                                cfg_we,
    input  logic [bcsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Column counter indexes the line store; widths for width compares
    localparam int AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int CW      = (WW > bcsf_pkg::GW_BITS) ? WW : bcsf_pkg::GW_BITS;
    localparam int YW      = bcsf_pkg::GH_BITS;
    localparam int RESET_W = (MAX_WIDTH < bcsf_pkg::RESET_SIZE) ? MAX_WIDTH
                                                                : bcsf_pkg::RESET_SIZE;

    // Per-beat decisions taken at accept, registered for the window stage
    typedef struct packed {
        logic emit_end;   // last cell of row y-2 leaves from mid-right
        logic emit_mid;   // cell (y-1, x-1) leaves after the shift
        logic on_rim;     // that cell sits on the grid border
        logic nb_top;
        logic nb_bot;
        logic nb_left;
        logic nb_right;
        logic last;       // final cell of the frame
    } cell_flags_t;

    // ------------------------------------------------------------------
    // Geometry, held as clamped values and their neighbours
    // ------------------------------------------------------------------
    logic [CW-1:0] wlast_reg, wlast_next;
    logic [YW-1:0] h_reg, h_next;
    logic [YW-1:0] hlast_reg, hlast_next;
    logic [YW-1:0] hp1_reg, hp1_next;
    logic [CW-1:0] w_raw, w_clamp;
    logic [YW-1:0] h_raw, h_clamp;

    always_comb
    begin
        w_raw = CW'(cfg_data[bcsf_pkg::GW_BITS-1:0]);
        h_raw = cfg_data[YW-1:0];

        if (w_raw < CW'(bcsf_pkg::MIN_SIZE))
        begin
            w_clamp = CW'(bcsf_pkg::MIN_SIZE);
        end
        else if (w_raw > CW'(MAX_WIDTH))
        begin
            w_clamp = CW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = w_raw;
        end

        if (h_raw < YW'(bcsf_pkg::MIN_SIZE))
        begin
            h_clamp = YW'(bcsf_pkg::MIN_SIZE);
        end
        else if (h_raw > YW'(bcsf_pkg::MAX_HEIGHT))
        begin
            h_clamp = YW'(bcsf_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_clamp = h_raw;
        end

        wlast_next = wlast_reg;
        h_next     = h_reg;
        hlast_next = hlast_reg;
        hp1_next   = hp1_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bcsf_pkg::REG_GRID_WIDTH:
                begin
                    wlast_next = w_clamp - CW'(1);
                end
                bcsf_pkg::REG_GRID_HEIGHT:
                begin
                    h_next     = h_clamp;
                    hlast_next = h_clamp - YW'(1);
                    hp1_next   = h_clamp + YW'(1);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= CW'(RESET_W - 1);
            h_reg     <= YW'(bcsf_pkg::RESET_SIZE);
            hlast_reg <= YW'(bcsf_pkg::RESET_SIZE - 1);
            hp1_reg   <= YW'(bcsf_pkg::RESET_SIZE + 1);
        end
        else
        begin
            wlast_reg <= wlast_next;
            h_reg     <= h_next;
            hlast_reg <= hlast_next;
            hp1_reg   <= hp1_next;
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: raster counters, line store read
    // ------------------------------------------------------------------
    logic [AW-1:0]    x_reg, x_next;
    logic [YW-1:0]    y_reg, y_next;
    logic [bcsf_pkg::OQ_CW-1:0] q_fill;
    logic             b_valid_reg;
    logic             accept;
    logic             draining;
    logic             proc;
    logic             cell_v;
    logic             col_zero;
    logic             row_end;
    logic             frame_end;
    cell_flags_t      flags;

    // Room for the queue contents, the beat in flight and this one
    assign in_ready = (q_fill + bcsf_pkg::OQ_CW'(b_valid_reg))
                      < bcsf_pkg::OQ_CW'(bcsf_pkg::OQ_DEPTH);

    assign accept    = in_valid && in_ready;
    assign draining  = (y_reg >= h_reg);
    // Flush beats mid-frame are taken and dropped; once drained all beats count
    assign proc      = accept && (draining || (in_data.kind == bcsf_pkg::KIND_CELL));
    assign cell_v    = !draining && in_data.wall_in;
    assign col_zero  = (x_reg == '0);
    assign row_end   = (CW'(x_reg) == wlast_reg);
    assign frame_end = col_zero && (y_reg == hp1_reg);

    always_comb
    begin
        flags.emit_end = col_zero && (y_reg >= YW'(2));
        flags.emit_mid = !col_zero && (y_reg != '0);
        flags.on_rim   = (y_reg == YW'(1)) || (y_reg == h_reg) || (x_reg == AW'(1));
        flags.nb_top   = (y_reg == YW'(2));
        flags.nb_bot   = (y_reg == hlast_reg);
        flags.nb_left  = (CW'(x_reg) == CW'(2));
        flags.nb_right = row_end;
        flags.last     = frame_end;
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        priority if (cfg_we)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (proc)
        begin
            priority if (frame_end)
            begin
                x_next = '0;
                y_next = '0;
            end
            else if (row_end)
            begin
                x_next = '0;
                y_next = y_reg + YW'(1);
            end
            else
            begin
                x_next = x_reg + AW'(1);
            end
        end
        else
        begin
            x_next = x_reg;
            y_next = y_reg;
        end
    end

    // ------------------------------------------------------------------
    // Window stage registers
    // ------------------------------------------------------------------
    logic             b_valid_next;
    logic [AW-1:0]    b_x_reg;
    logic             b_v_reg;
    cell_flags_t      b_flags_reg;
    logic [8:0]       win_reg, win_next;

    assign b_valid_next = proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            b_valid_reg <= b_valid_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            b_x_reg     <= x_reg;
            b_v_reg     <= cell_v;
            b_flags_reg <= flags;
        end
    end

    // ------------------------------------------------------------------
    // Line store: word = {upper, middle}; upper takes old middle, middle
    // takes the new cell
    // ------------------------------------------------------------------
    logic [1:0]       line_mem [MAX_WIDTH];
    logic [1:0]       mem_rd_reg;
    logic             fwd_reg;
    logic [1:0]       fwd_data_reg;
    logic [1:0]       line_word;
    logic [1:0]       line_wr;
    logic             up_bit;
    logic             mid_bit;

    assign line_word = fwd_reg ? fwd_data_reg : mem_rd_reg;
    assign up_bit    = line_word[1];
    assign mid_bit   = line_word[0];
    assign line_wr   = {mid_bit, b_v_reg};

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            line_mem[b_x_reg] <= line_wr;
        end
        if (proc)
        begin
            mem_rd_reg   <= line_mem[x_reg];
            // same column written this cycle: take the new word
            fwd_reg      <= b_valid_reg && (b_x_reg == x_reg);
            fwd_data_reg <= line_wr;
        end
    end

    // ------------------------------------------------------------------
    // Window shift and cell rule
    // ------------------------------------------------------------------
    logic [8:0]           win_shift;
    logic [8:0]           forced;
    logic                 res_val;
    logic                 push;
    bcsf_pkg::out_beat_t  res_beat;

    always_comb
    begin
        win_shift = {b_v_reg, win_reg[8:7], mid_bit, win_reg[5:4], up_bit, win_reg[2:1]};

        forced = '0;
        if (b_flags_reg.nb_top)
        begin
            forced = forced | bcsf_pkg::MASK_TOP;
        end
        if (b_flags_reg.nb_bot)
        begin
            forced = forced | bcsf_pkg::MASK_BOT;
        end
        if (b_flags_reg.nb_left)
        begin
            forced = forced | bcsf_pkg::MASK_LEFT;
        end
        if (b_flags_reg.nb_right)
        begin
            forced = forced | bcsf_pkg::MASK_RIGHT;
        end

        priority if (b_flags_reg.emit_end)
        begin
            // right-hand border cell, taken before the shift
            res_val = win_reg[bcsf_pkg::WIN_MID_RIGHT];
        end
        else if (b_flags_reg.on_rim)
        begin
            res_val = win_shift[bcsf_pkg::WIN_CENTRE];
        end
        else
        begin
            res_val = bcsf_pkg::smooth_rule(win_shift, forced);
        end

        res_beat.wall_out   = res_val;
        res_beat.frame_last = b_flags_reg.last;
        push = b_valid_reg && (b_flags_reg.emit_end || b_flags_reg.emit_mid);

        win_next = win_reg;
        priority if (cfg_we)
        begin
            win_next = '0;
        end
        else if (b_valid_reg)
        begin
            win_next = b_flags_reg.last ? 9'b0 : win_shift;
        end
        else
        begin
            win_next = win_reg;
        end
    end

    bcsf_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res_beat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .fill      (q_fill)
    );

endmodule
